@@ hdl/amp_pkg.sv @@
// amp_pkg: shared types and constants for the adc median-3 pcm packer
// no dependencies; used by amp_convert, amp_median_pack and the top level
`default_nettype none

package amp_pkg;

    // width of one pcm16 sample and of the packed output word
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 12;
    localparam int PACK_N   = 4;
    localparam int WORD_W   = SAMPLE_W * PACK_N;
    localparam int INDEX_W  = 6;

    // dc offset reset value in adc codes
    localparam logic [CODE_W-1:0] DC_OFFSET_RESET = 12'd1970;

    // depth of the block store that the word index counts through
    localparam int BLOCK_DEPTH_WORDS = 64;
    localparam int WORD_CNT_W = (BLOCK_DEPTH_WORDS > 1) ? $clog2(BLOCK_DEPTH_WORDS) : 1;

    // converted sample handed from the input stage to the filter stage
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } t_smp_xfer;

endpackage

`default_nettype wire

@@ hdl/amp_convert.sv @@
// amp_convert: dc offset register and input stage (12-bit code to pcm16)
// depends on amp_pkg
`default_nettype none

module amp_convert (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [amp_pkg::CODE_W-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [amp_pkg::SAMPLE_W-1:0] i_adc_raw,
    input  wire logic                        i_end_of_read,
    input  wire logic                        i_take,
    output amp_pkg::t_smp_xfer               o_xfer
);

    logic [amp_pkg::CODE_W-1:0]   r_dc_offset;
    logic                         r_valid;
    logic                         r_last;
    logic [amp_pkg::SAMPLE_W-1:0] r_sample;
    logic [amp_pkg::CODE_W-1:0]   n_diff;
    logic                         w_accept;

    // dc offset register, to be written only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset <= amp_pkg::DC_OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_dc_offset <= i_cfg_data;
        end
    end

    // stage is free when empty or when its sample moves on this cycle
    assign o_in_stall = r_valid && !i_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    // difference wraps in 12 bits; the shift by 4 keeps exactly 16 bits
    assign n_diff = i_adc_raw[amp_pkg::CODE_W-1:0] - r_dc_offset;

    // input register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // input register: payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= {n_diff, 4'b0000};
            r_last   <= i_end_of_read;
        end
    end

    assign o_xfer.valid  = r_valid;
    assign o_xfer.last   = r_last;
    assign o_xfer.sample = r_sample;

endmodule

`default_nettype wire

@@ hdl/amp_median_pack.sv @@
// amp_median_pack: three-tap median window, four-sample packer and result register
// depends on amp_pkg
`default_nettype none

module amp_median_pack (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire amp_pkg::t_smp_xfer            i_xfer,
    output logic                               o_take,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [amp_pkg::WORD_W-1:0]         o_packed_word,
    output logic [amp_pkg::INDEX_W-1:0]        o_word_index
);

    localparam int SW = amp_pkg::SAMPLE_W;
    localparam int CW = amp_pkg::WORD_CNT_W;
    localparam int PW = amp_pkg::SAMPLE_W * (amp_pkg::PACK_N - 1);

    logic [SW-1:0]            r_older;
    logic [SW-1:0]            r_newer;
    logic [1:0]               r_fill;
    logic [1:0]               r_pack_cnt;
    logic [PW-1:0]            r_pack;
    logic [CW-1:0]            r_word_cnt;
    logic                     r_out_valid;
    logic [amp_pkg::WORD_W-1:0] r_out_word;
    logic [amp_pkg::INDEX_W-1:0] r_out_index;

    logic signed [SW-1:0]     w_a;
    logic signed [SW-1:0]     w_b;
    logic signed [SW-1:0]     w_c;
    logic signed [SW-1:0]     w_lo;
    logic signed [SW-1:0]     w_hi;
    logic signed [SW-1:0]     w_mid;
    logic [SW-1:0]            w_med;
    logic                     w_full;
    logic                     w_emit;
    logic [PW-1:0]            n_pack;
    logic [CW-1:0]            n_word_cnt;
    logic [amp_pkg::INDEX_W-1:0] w_index;

    // signed median of the window and the incoming sample
    assign w_a   = r_older;
    assign w_b   = r_newer;
    assign w_c   = i_xfer.sample;
    assign w_lo  = (w_a < w_b) ? w_a : w_b;
    assign w_hi  = (w_a < w_b) ? w_b : w_a;
    assign w_mid = (w_hi < w_c) ? w_hi : w_c;
    assign w_med = (w_lo > w_mid) ? w_lo : w_mid;

    assign w_full = (r_fill == 2'd2);
    assign w_emit = w_full && (r_pack_cnt == 2'd3);

    // a sample that fills no word can always move; a word needs a free result register
    assign o_take = i_xfer.valid && (!w_emit || !r_out_valid || !i_out_stall);

    // place the median into the partial pack
    always_comb begin
        n_pack = r_pack;
        case (r_pack_cnt)
            2'd0:    n_pack[SW-1:0]      = w_med;
            2'd1:    n_pack[2*SW-1:SW]   = w_med;
            2'd2:    n_pack[3*SW-1:2*SW] = w_med;
            default: n_pack = r_pack;
        endcase
    end

    // word counter wraps at the block depth
    assign n_word_cnt = (r_word_cnt == CW'(amp_pkg::BLOCK_DEPTH_WORDS - 1)) ? '0
                                                                          : r_word_cnt + 1'b1;

    // index field carries the low bits of the counter
    generate
        if (CW >= amp_pkg::INDEX_W) begin : g_idx_cut
            assign w_index = r_word_cnt[amp_pkg::INDEX_W-1:0];
        end else begin : g_idx_ext
            assign w_index = {{(amp_pkg::INDEX_W - CW){1'b0}}, r_word_cnt};
        end
    endgenerate

    // window, pack and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older    <= '0;
            r_newer    <= '0;
            r_fill     <= 2'd0;
            r_pack_cnt <= 2'd0;
            r_pack     <= '0;
            r_word_cnt <= '0;
        end else if (o_take) begin
            if (w_emit) begin
                r_word_cnt <= n_word_cnt;
            end
            if (i_xfer.last) begin
                r_older    <= '0;
                r_newer    <= '0;
                r_fill     <= 2'd0;
                r_pack_cnt <= 2'd0;
                r_pack     <= '0;
            end else begin
                r_older <= r_newer;
                r_newer <= i_xfer.sample;
                if (!w_full) begin
                    r_fill <= r_fill + 2'd1;
                end else if (w_emit) begin
                    r_pack_cnt <= 2'd0;
                    r_pack     <= '0;
                end else begin
                    r_pack_cnt <= r_pack_cnt + 2'd1;
                    r_pack     <= n_pack;
                end
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_out_word  <= {w_med, r_pack};
            r_out_index <= w_index;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_word = r_out_word;
    assign o_word_index  = r_out_index;

    // a partial pack only exists while the window is full
    a_pack_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pack_cnt != 2'd0) |-> (r_fill == 2'd2))
        else $error("partial pack without a full window");

    // window fill never exceeds two
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != 2'd3))
        else $error("window fill out of range");

    // a completed word always lands in the result register
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && w_emit) |=> r_out_valid)
        else $error("emitted word not held in result register");

    // end of read leaves an empty window and pack
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_xfer.last) |=> (r_fill == 2'd0 && r_pack_cnt == 2'd0))
        else $error("end of read did not clear window");

    // the word counter moves only when a new word is loaded
    a_cnt_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !w_emit) |=> $stable(r_word_cnt))
        else $error("word counter moved without a word");

endmodule

`default_nettype wire

@@ hdl/adc_median3_pcm_packer.sv @@
// adc_median3_pcm_packer: top level of the adc median-3 filter and pcm16 packer
// depends on amp_pkg, amp_convert and amp_median_pack
//
//   channel  direction  handshake                 payload
//   cfg      in         i_cfg_we                  i_cfg_data (dc offset, 12 bit)
//   in       in         i_in_valid / o_in_stall   i_adc_raw, i_end_of_read
//   out      out        o_out_valid / i_out_stall o_packed_word, o_word_index
//
// one sample per clock while the input does not stall; two register stages (input register,
// result register): a completing sample passes the input register, then the result register
// i_rst_n is synchronous and active low; dc offset resets to 1970, all else to empty
// while a completing sample waits on a held result, the input stalls; other samples pass
`default_nettype none

module adc_median3_pcm_packer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [amp_pkg::CODE_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [amp_pkg::SAMPLE_W-1:0]  i_adc_raw,
    input  wire logic                          i_end_of_read,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [amp_pkg::WORD_W-1:0]         o_packed_word,
    output logic [amp_pkg::INDEX_W-1:0]        o_word_index
);

    amp_pkg::t_smp_xfer w_xfer;
    logic               w_take;

    // input stage with offset removal and scaling
    amp_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_adc_raw     (i_adc_raw),
        .i_end_of_read (i_end_of_read),
        .i_take        (w_take),
        .o_xfer        (w_xfer)
    );

    // median window, packer and result register
    amp_median_pack u_median_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_xfer        (w_xfer),
        .o_take        (w_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packed_word (o_packed_word),
        .o_word_index  (o_word_index)
    );

endmodule

`default_nettype wire

@@ test/adc_median3_pcm_packer_tb.sv @@
// adc_median3_pcm_packer_tb: self-checking bench for the median-3 filter and pcm16 packer
// needs amp_pkg and adc_median3_pcm_packer; a directed table then random reads,
// every packed word checked against a behavioural copy of the filter or a typed table value
`timescale 1ns / 100ps

module adc_median3_pcm_packer_tb;

    localparam int SAMPLE_W          = amp_pkg::SAMPLE_W;
    localparam int CODE_W            = amp_pkg::CODE_W;
    localparam int WORD_W            = amp_pkg::WORD_W;
    localparam int INDEX_W           = amp_pkg::INDEX_W;
    localparam int BLOCK_DEPTH_WORDS = amp_pkg::BLOCK_DEPTH_WORDS;
    localparam logic [CODE_W-1:0] DC_OFFSET_RESET = amp_pkg::DC_OFFSET_RESET;

    localparam int          RANDOM_ITEMS = 650;
    localparam int          SETTLE_CYCLES = 5;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // one packed word as it leaves the block
    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic [INDEX_W-1:0] word_index;
    } t_pcm_word;

    // one row of the directed table: an offset write or a sample
    typedef struct packed {
        logic               is_offset;
        logic [CODE_W-1:0]  offset;
        logic [15:0]        adc_raw;
        logic               end_of_read;
        logic               typed;
        logic [WORD_W-1:0]  want_word;
        logic [INDEX_W-1:0] want_index;
    } t_stim_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CODE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_adc_raw;
    logic                 i_end_of_read;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_packed_word;
    logic [INDEX_W-1:0]   o_word_index;

    // typed expectation travelling alongside the sample it belongs to
    logic                 row_typed;
    logic [WORD_W-1:0]    row_want_word;
    logic [INDEX_W-1:0]   row_want_index;

    // behavioural copy of the filter state
    logic [CODE_W-1:0]    offset_model;
    logic [SAMPLE_W-1:0]  smp_older;
    logic [SAMPLE_W-1:0]  smp_newer;
    int                   win_fill;
    int                   pack_fill;
    logic [47:0]          pack_acc;
    int                   word_count;

    t_pcm_word            words_due[$];
    t_stim_row            dir_table[$];

    int unsigned          cycle_count = 0;
    int                   fail_count = 0;
    int                   burst_left = 1;
    bit                   idle_on = 1'b1;
    t_stall_mode          stall_mode = STALL_NONE;
    int                   stall_hold = 0;

    adc_median3_pcm_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_adc_raw     (i_adc_raw),
        .i_end_of_read (i_end_of_read),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packed_word (o_packed_word),
        .o_word_index  (o_word_index)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("adc_median3_pcm_packer_tb: FAIL");
            $finish;
        end
    end

    // receiver back-pressure, switching to a randomly picked pattern whenever the hold count runs out
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(50, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 99) < 80);
            STALL_PERIODIC: i_out_stall <= ((cycle_count % 9) < 4);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // filter one accepted sample; queue the packed word it completes, if any
    task automatic filter_sample(input logic [15:0] adc, input logic last,
                                 input logic typed, input logic [WORD_W-1:0] want_word,
                                 input logic [INDEX_W-1:0] want_index);
        logic [SAMPLE_W-1:0] pcm;
        logic signed [15:0]  a, b, c, t;
        t_pcm_word           done;
        pcm = {adc[11:0] - offset_model, 4'h0};
        if (win_fill >= 2) begin
            a = $signed(smp_older);
            b = $signed(smp_newer);
            c = $signed(pcm);
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
            if (pack_fill == 3) begin
                done.packed_word = {b, pack_acc};
                done.word_index  = word_count[INDEX_W-1:0];
                word_count = (word_count + 1) % BLOCK_DEPTH_WORDS;
                pack_acc  = '0;
                pack_fill = 0;
                if (typed) begin
                    done.packed_word = want_word;
                    done.word_index  = want_index;
                end
                words_due.push_back(done);
            end else begin
                pack_acc[16*pack_fill +: 16] = b;
                pack_fill++;
            end
        end else begin
            win_fill++;
        end
        smp_older = smp_newer;
        smp_newer = pcm;
        // end of read drops the window and any partial word
        if (last) begin
            smp_older = '0;
            smp_newer = '0;
            win_fill  = 0;
            pack_fill = 0;
            pack_acc  = '0;
        end
    endtask

    task automatic note_failure(input string what, input t_pcm_word want);
        fail_count++;
        if (fail_count <= 10)
            $display({"mismatch (%s) at cycle %0d: expected word %h index %0d,",
                      " got word %h index %0d"},
                     what, cycle_count, want.packed_word, want.word_index,
                     o_packed_word, o_word_index);
    endtask

    // sample and result transactions
    always @(posedge i_clk) begin
        t_pcm_word want;
        if (i_rst_n === 1'b1 && i_in_valid && o_in_stall === 1'b0)
            filter_sample(i_adc_raw, i_end_of_read, row_typed, row_want_word, row_want_index);
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            if (words_due.size() == 0) begin
                want = '0;
                note_failure("unexpected word", want);
            end else begin
                want = words_due.pop_front();
                if (o_packed_word !== want.packed_word || o_word_index !== want.word_index)
                    note_failure("wrong word", want);
            end
        end
    end

    // offer one sample and hold it until taken, then maybe pause
    task automatic send_sample(input logic [15:0] adc, input logic last, input logic typed,
                               input logic [WORD_W-1:0] want_word,
                               input logic [INDEX_W-1:0] want_index);
        i_in_valid     <= 1'b1;
        i_adc_raw      <= adc;
        i_end_of_read  <= last;
        row_typed      <= typed;
        row_want_word  <= want_word;
        row_want_index <= want_index;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (idle_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // offset write once the block has gone quiet
    task automatic write_offset(input logic [CODE_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        offset_model = value;
    endtask

    function automatic t_stim_row row_sample(input logic [15:0] adc, input logic last);
        t_stim_row r;
        r = '0;
        r.adc_raw     = adc;
        r.end_of_read = last;
        return r;
    endfunction

    function automatic t_stim_row row_typed_word(input logic [15:0] adc,
                                                 input logic [15:0] pcm,
                                                 input logic [INDEX_W-1:0] idx);
        t_stim_row r;
        r = row_sample(adc, 1'b1);
        r.typed      = 1'b1;
        r.want_word  = {pcm, pcm, pcm, pcm};
        r.want_index = idx;
        return r;
    endfunction

    function automatic t_stim_row row_offset(input logic [CODE_W-1:0] value);
        t_stim_row r;
        r = '0;
        r.is_offset = 1'b1;
        r.offset    = value;
        return r;
    endfunction

    initial begin
        t_stim_row        row;
        logic [15:0]      adc;
        logic [15:0]      prev_adc;
        int unsigned      near;
        int               random_sent;
        int               phase_left;
        int               read_len;
        int               pick;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_adc_raw      = '0;
        i_end_of_read  = 1'b0;
        row_typed      = 1'b0;
        row_want_word  = '0;
        row_want_index = '0;
        offset_model   = DC_OFFSET_RESET;
        smp_older      = '0;
        smp_newer      = '0;
        win_fill       = 0;
        pack_fill      = 0;
        pack_acc       = '0;
        word_count     = 0;
        prev_adc       = '0;
        random_sent    = 0;

        // reset offset: a code equal to the offset packs to zero
        repeat (5) dir_table.push_back(row_sample(16'h07B2, 1'b0));
        dir_table.push_back(row_typed_word(16'h07B2, 16'h0000, 6'd0));
        // top code with upper bits set, wraps past +32767
        repeat (5) dir_table.push_back(row_sample(16'hFFFF, 1'b0));
        dir_table.push_back(row_typed_word(16'hFFFF, 16'h84D0, 6'd1));
        // partial word thrown away at end of read
        dir_table.push_back(row_sample(16'h1234, 1'b0));
        dir_table.push_back(row_sample(16'hA987, 1'b0));
        dir_table.push_back(row_sample(16'h5FFF, 1'b1));
        // offset extremes
        dir_table.push_back(row_offset(12'h000));
        repeat (5) dir_table.push_back(row_sample(16'h0FFF, 1'b0));
        dir_table.push_back(row_typed_word(16'h0FFF, 16'hFFF0, 6'd2));
        dir_table.push_back(row_offset(12'hFFF));
        repeat (5) dir_table.push_back(row_sample(16'hF000, 1'b0));
        dir_table.push_back(row_typed_word(16'hF000, 16'h0010, 6'd3));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[n]) begin
            row = dir_table[n];
            if (row.is_offset)
                write_offset(row.offset);
            else
                send_sample(row.adc_raw, row.end_of_read, row.typed,
                            row.want_word, row.want_index);
        end

        // random reads in phases, each under its own offset and sender pattern
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       write_offset(12'h000);
                1:       write_offset(12'hFFF);
                2:       write_offset(DC_OFFSET_RESET);
                3:       write_offset(12'h800);
                default: write_offset(CODE_W'($urandom));
            endcase
            idle_on    = ($urandom_range(0, 3) != 0);
            phase_left = $urandom_range(60, 140);
            while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    read_len = $urandom_range(1, 6);
                else if (pick < 9)
                    read_len = $urandom_range(7, 60);
                else
                    read_len = $urandom_range(61, 200);
                // a phase may end mid-read, leaving the window across the offset write
                for (int k = 0; k < read_len && phase_left > 0; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15) begin
                        adc = prev_adc;
                    end else if (pick < 55) begin
                        adc = 16'($urandom);
                    end else begin
                        near = offset_model + $urandom_range(0, 600) - 300;
                        adc  = {4'($urandom_range(0, 15)), near[11:0]};
                    end
                    send_sample(adc, (k == read_len - 1), 1'b0, '0, '0);
                    prev_adc = adc;
                    phase_left--;
                    random_sent++;
                end
            end
        end

        // wait out the last words
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && words_due.size() == 0) begin
            $display("adc_median3_pcm_packer_tb: PASS");
        end else begin
            $display("adc_median3_pcm_packer_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ adc_median3_pcm_packer.f @@
hdl/amp_pkg.sv
hdl/amp_convert.sv
hdl/amp_median_pack.sv
hdl/adc_median3_pcm_packer.sv
test/adc_median3_pcm_packer_tb.sv
